// File: hw/rtl/ecs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecs_pkg
// Types and constants shared by the expo curve shaper modules.
// ----------------------------------------------------------------------------
package ecs_pkg;

  localparam int MAX_W    = 15;
  localparam int PCT_W    = 7;
  localparam int X_W      = 10;
  localparam int SCALE_SH = 9;
  localparam int REM_W    = MAX_W + SCALE_SH;
  localparam int CUBE_SH  = 16;
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = 18;

  localparam logic [PCT_W-1:0]   PCT_RANGE = 7'd100;
  localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;
  localparam logic [5:0]         ROUND_ADD = 6'd50;

  localparam logic REG_MAX_VALUE    = 1'b0;
  localparam logic REG_EXPO_PERCENT = 1'b1;

  typedef struct packed {
    logic             neg;
    logic [REM_W-1:0] rem;
    logic [X_W-1:0]   quot;
    logic [MAX_W-1:0] mval;
    logic [PCT_W-1:0] pct;
  } div_stage_t;

endpackage
`default_nettype wire

// File: hw/rtl/expo_curve_shaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// expo_curve_shaper
// Cubic expo curve on a signed sample: saturate, scale to +/-512 through a
// row of ten division cells, blend the cube with the linear term, rescale.
// The start transfer is registered, then passes through the division cells and the curve pipeline to out_valid.
// One sample is taken every cycle while busy is low; busy is high during reset and in the first
// cycle after reset is released. Synchronous reset restores max_value 512 and expo_percent 0.
// ----------------------------------------------------------------------------
module expo_curve_shaper #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire signed [SAMPLE_BITS-1:0] in_sample,
  output logic                         out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_shaped,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire [ecs_pkg::MAX_W-1:0]     cfg_wdata
);
  import ecs_pkg::*;

  localparam int MAG_W = (SAMPLE_BITS + 1 > MAX_W + 1) ? SAMPLE_BITS + 1 : MAX_W + 1;

  logic [MAX_W-1:0] max_value_r;
  logic [PCT_W-1:0] expo_percent_r;
  logic             ready_r;

  logic                   in_vld_r;
  logic [SAMPLE_BITS-1:0] in_s_r;

  logic [MAX_W-1:0] m_eff;
  logic [PCT_W-1:0] p_eff;
  logic [MAG_W-1:0] s_mag;
  logic [MAX_W-1:0] clamped;
  div_stage_t       head;

  logic       vld_chain [0:X_W];
  div_stage_t pay_chain [0:X_W];

  logic               res_vld;
  logic signed [18:0] res;
  logic signed [32:0] res_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r    <= MAX_W'(512);
      expo_percent_r <= '0;
      ready_r        <= 1'b0;
      in_vld_r       <= 1'b0;
    end else begin
      ready_r  <= 1'b1;
      in_vld_r <= start & ready_r;
      if (cfg_we && cfg_index == REG_MAX_VALUE) begin
        max_value_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_EXPO_PERCENT) begin
        expo_percent_r <= cfg_wdata[PCT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    in_s_r <= in_sample;
  end

  always_comb begin
    m_eff = (max_value_r == '0) ? MAX_W'(1) : max_value_r;
    p_eff = (expo_percent_r > PCT_RANGE) ? PCT_RANGE : expo_percent_r;
    if (in_s_r[SAMPLE_BITS-1]) begin
      s_mag = MAG_W'(-$signed({in_s_r[SAMPLE_BITS-1], in_s_r}));
    end else begin
      s_mag = MAG_W'({1'b0, in_s_r});
    end
    clamped   = (s_mag > MAG_W'(m_eff)) ? m_eff : s_mag[MAX_W-1:0];
    head.neg  = in_s_r[SAMPLE_BITS-1];
    head.rem  = {clamped, {SCALE_SH{1'b0}}};
    head.quot = '0;
    head.mval = m_eff;
    head.pct  = p_eff;
  end

  assign vld_chain[0] = in_vld_r;
  assign pay_chain[0] = head;

  for (genvar i = 0; i < X_W; i++) begin : g_div
    ecs_div_cell #(
      .SHIFT(X_W - 1 - i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_in (vld_chain[i]),
      .d_in   (pay_chain[i]),
      .vld_out(vld_chain[i+1]),
      .d_out  (pay_chain[i+1])
    );
  end

  ecs_curve_pipe u_curve (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (vld_chain[X_W]),
    .d_in   (pay_chain[X_W]),
    .vld_out(res_vld),
    .res_out(res)
  );

  assign res_ext    = 33'(res);
  assign busy       = ~ready_r;
  assign out_valid  = res_vld;
  assign out_shaped = res_ext[SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/ecs_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecs_div_cell
// One restoring division step: decides one quotient bit and passes the
// partial remainder on to the next cell.
// ----------------------------------------------------------------------------
module ecs_div_cell #(
  parameter int SHIFT = 0
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      vld_in,
  input  ecs_pkg::div_stage_t      d_in,
  output logic                     vld_out,
  output ecs_pkg::div_stage_t      d_out
);
  import ecs_pkg::*;

  logic [REM_W:0] divisor;
  logic [REM_W:0] trial;
  logic           take;
  div_stage_t     d_nxt;
  logic           vld_r;
  div_stage_t     d_r;

  always_comb begin
    divisor = {{(REM_W + 1 - MAX_W){1'b0}}, d_in.mval} << SHIFT;
    trial   = {1'b0, d_in.rem} - divisor;
    take    = ~trial[REM_W];
    d_nxt   = d_in;
    if (take) begin
      d_nxt.rem  = trial[REM_W-1:0];
      d_nxt.quot = d_in.quot | (X_W'(1) << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule
`default_nettype wire

// File: hw/rtl/ecs_curve_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecs_curve_pipe
// Cubic blend, rounding divide by one hundred and rescale to full range,
// in seven registered stages.
// ----------------------------------------------------------------------------
module ecs_curve_pipe (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   vld_in,
  input  ecs_pkg::div_stage_t   d_in,
  output logic                  vld_out,
  output logic signed [18:0]    res_out
);
  import ecs_pkg::*;

  logic [6:0] vld_r;

  logic [X_W-1:0]   s1_ax_r;
  logic [19:0]      s1_sq_r;
  logic [16:0]      s1_lin_r;
  logic             s1_neg_r;
  logic [MAX_W-1:0] s1_m_r;
  logic [PCT_W-1:0] s1_p_r;

  logic [29:0]      s2_cube_r;
  logic [16:0]      s2_lin_r;
  logic             s2_neg_r;
  logic [MAX_W-1:0] s2_m_r;
  logic [PCT_W-1:0] s2_p_r;

  logic [18:0]      s3_cp_r;
  logic [16:0]      s3_lin_r;
  logic             s3_neg_r;
  logic [MAX_W-1:0] s3_m_r;

  logic [17:0]      s4_t_r;
  logic             s4_neg_r;
  logic [MAX_W-1:0] s4_m_r;

  logic [35:0]      s5_prod_r;
  logic             s5_neg_r;
  logic [MAX_W-1:0] s5_m_r;

  logic [26:0]      s6_rm_r;
  logic             s6_neg_r;

  logic signed [18:0] s7_res_r;

  logic [17:0] sum_a;
  logic [17:0] t_nxt;
  logic        tneg_nxt;
  logic [17:0] rmag;

  always_comb begin
    sum_a = {1'b0, s3_cp_r[18:2]} + {1'b0, s3_lin_r};
    if (!s3_neg_r) begin
      t_nxt    = sum_a + 18'(ROUND_ADD);
      tneg_nxt = 1'b0;
    end else if (sum_a >= 18'(ROUND_ADD)) begin
      t_nxt    = sum_a - 18'(ROUND_ADD);
      tneg_nxt = 1'b1;
    end else begin
      t_nxt    = 18'(ROUND_ADD) - sum_a;
      tneg_nxt = 1'b0;
    end
    rmag = s6_rm_r[26:SCALE_SH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    s1_ax_r   <= d_in.quot;
    s1_sq_r   <= d_in.quot * d_in.quot;
    s1_lin_r  <= (PCT_RANGE - d_in.pct) * d_in.quot;
    s1_neg_r  <= d_in.neg;
    s1_m_r    <= d_in.mval;
    s1_p_r    <= d_in.pct;

    s2_cube_r <= s1_sq_r * s1_ax_r;
    s2_lin_r  <= s1_lin_r;
    s2_neg_r  <= s1_neg_r;
    s2_m_r    <= s1_m_r;
    s2_p_r    <= s1_p_r;

    s3_cp_r   <= s2_cube_r[27:CUBE_SH] * s2_p_r;
    s3_lin_r  <= s2_lin_r;
    s3_neg_r  <= s2_neg_r;
    s3_m_r    <= s2_m_r;

    s4_t_r    <= t_nxt;
    s4_neg_r  <= tneg_nxt;
    s4_m_r    <= s3_m_r;

    s5_prod_r <= s4_t_r * RECIP_100;
    s5_neg_r  <= s4_neg_r;
    s5_m_r    <= s4_m_r;

    s6_rm_r   <= s5_prod_r[35:RECIP_SH] * s5_m_r;
    s6_neg_r  <= s5_neg_r;

    s7_res_r  <= s6_neg_r ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  end

  assign vld_out = vld_r[6];
  assign res_out = s7_res_r;

endmodule
`default_nettype wire
